### rtl/core/asn1t_pkg.sv
// ----------------------------------------------------------------------------
// asn1t_pkg
// Types and constants shared by the ASN.1 time string parser.
// ----------------------------------------------------------------------------
`default_nettype none

package asn1t_pkg;

  // string formats
  localparam logic [1:0] FMT_UTC = 2'd0;
  localparam logic [1:0] FMT_GEN = 2'd1;

  // characters
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_Z     = 8'h5A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;

  // parse positions
  localparam logic [4:0] PH_YEAR_HI  = 5'd0;
  localparam logic [4:0] PH_YY_HI    = 5'd2;
  localparam logic [4:0] PH_SEC_HI   = 5'd12;
  localparam logic [4:0] PH_AFTER    = 5'd14;
  localparam logic [4:0] PH_FRAC1    = 5'd15;
  localparam logic [4:0] PH_FRAC     = 5'd16;
  localparam logic [4:0] PH_ZONE     = 5'd17;
  localparam logic [4:0] PH_ZONE_MLO = 5'd20;
  localparam logic [4:0] PH_DONE     = 5'd21;

  // digit-pair field codes
  localparam logic [2:0] FLD_CENT = 3'd0;
  localparam logic [2:0] FLD_YY   = 3'd1;
  localparam logic [2:0] FLD_MON  = 3'd2;
  localparam logic [2:0] FLD_DAY  = 3'd3;
  localparam logic [2:0] FLD_HOUR = 3'd4;
  localparam logic [2:0] FLD_MIN  = 3'd5;
  localparam logic [2:0] FLD_SEC  = 3'd6;

  localparam logic [6:0] FIELD_MIN [0:7] = '{7'd0, 7'd0, 7'd1, 7'd1, 7'd0, 7'd0, 7'd0, 7'd0};
  localparam logic [6:0] FIELD_MAX [0:7] =
    '{7'd99, 7'd99, 7'd12, 7'd31, 7'd23, 7'd59, 7'd59, 7'd0};

  localparam logic [6:0] ZONE_HOUR_MAX = 7'd12;
  localparam logic [6:0] ZONE_MIN_MAX  = 7'd59;
  localparam logic [6:0] YEAR_PIVOT    = 7'd50;
  localparam logic [5:0] MIN_LEN_GEN   = 6'd13;
  localparam logic [5:0] MIN_LEN_UTC   = 6'd11;
  localparam logic [5:0] CNT_MAX       = 6'd63;

  typedef struct packed {
    logic [4:0]  phase;
    logic [5:0]  char_count;
    logic [3:0]  high_digit;
    logic        failed;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic        zone_present;
    logic        zone_negative;
    logic [3:0]  zone_hours;
    logic [5:0]  zone_minutes;
  } st_t;

  typedef struct packed {
    logic        valid_res;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic        zone_present;
    logic        zone_negative;
    logic [3:0]  zone_hours;
    logic [5:0]  zone_minutes;
  } res_t;

endpackage

`default_nettype wire

### rtl/core/asn1t_in_if.sv
// ----------------------------------------------------------------------------
// asn1t_in_if
// Character channel: one beat per character of the time string.
// ----------------------------------------------------------------------------
`default_nettype none

interface asn1t_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic [1:0] format;
  logic       last;

  modport source (output valid, output ch, output format, output last, input ready);
  modport sink   (input valid, input ch, input format, input last, output ready);
endinterface

`default_nettype wire

### rtl/core/asn1t_out_if.sv
// ----------------------------------------------------------------------------
// asn1t_out_if
// Result channel: one beat per parsed time string.
// ----------------------------------------------------------------------------
`default_nettype none

interface asn1t_out_if;
  logic        valid;
  logic        ready;
  logic        valid_res;
  logic [13:0] year;
  logic [3:0]  month;
  logic [4:0]  day;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  second;
  logic        zone_present;
  logic        zone_negative;
  logic [3:0]  zone_hours;
  logic [5:0]  zone_minutes;

  modport source (
    output valid, output valid_res, output year, output month, output day, output hour,
    output minute, output second, output zone_present, output zone_negative,
    output zone_hours, output zone_minutes, input ready
  );
  modport sink (
    input valid, input valid_res, input year, input month, input day, input hour,
    input minute, input second, input zone_present, input zone_negative,
    input zone_hours, input zone_minutes, output ready
  );
endinterface

`default_nettype wire

### rtl/core/asn1t_step.sv
// ----------------------------------------------------------------------------
// asn1t_step
// Parser step: applies one character to the parse state and forms the result.
// ----------------------------------------------------------------------------
`default_nettype none

module asn1t_step #(
  parameter int MAX_LEN = 32
) (
  input  asn1t_pkg::st_t  st,
  input  logic [7:0]      ch,
  input  logic [1:0]      format,
  input  logic            last,
  output asn1t_pkg::st_t  st_next,
  output asn1t_pkg::res_t res
);

  asn1t_pkg::st_t s;
  logic           is_digit;
  logic [3:0]     dig;
  logic [6:0]     pair;
  logic [2:0]     fld;
  logic [4:0]     ph;
  logic [5:0]     cnt;
  logic           ok;
  logic           zs_hit;
  logic [5:0]     min_len;
  logic           good;

  assign is_digit = (ch >= asn1t_pkg::CH_ZERO) && (ch <= asn1t_pkg::CH_NINE);
  assign dig      = ch[3:0];
  assign pair     = ({3'b000, st.high_digit} * 7'd10) + {3'b000, dig};
  assign cnt      = (st.char_count == asn1t_pkg::CNT_MAX) ? asn1t_pkg::CNT_MAX
                                                          : st.char_count + 6'd1;
  assign ph       = (st.char_count == 6'd0 && format == asn1t_pkg::FMT_UTC)
                    ? asn1t_pkg::PH_YY_HI : st.phase;
  assign fld      = ph[3:1];
  assign zs_hit   = (ch == asn1t_pkg::CH_Z) || (ch == asn1t_pkg::CH_PLUS) ||
                    (ch == asn1t_pkg::CH_MINUS);

  always_comb begin
    s            = st;
    s.phase      = ph;
    s.char_count = cnt;
    ok           = 1'b1;
    if ({1'b0, cnt} > 7'(MAX_LEN)) begin
      s.failed = 1'b1;
    end
    if (!s.failed) begin
      // zone start ('Z', '+', '-') is shared by several positions
      if ((ph == asn1t_pkg::PH_SEC_HI || ph == asn1t_pkg::PH_AFTER ||
           (ph == asn1t_pkg::PH_FRAC && !is_digit)) && zs_hit &&
          !(ph == asn1t_pkg::PH_AFTER && ch == asn1t_pkg::CH_DOT)) begin
        if (ph == asn1t_pkg::PH_SEC_HI) begin
          s.second = 6'd0;
        end
        if (ch == asn1t_pkg::CH_Z) begin
          s.phase = asn1t_pkg::PH_DONE;
        end else begin
          s.zone_present  = 1'b1;
          s.zone_negative = (ch == asn1t_pkg::CH_MINUS);
          s.zone_hours    = 4'd0;
          s.zone_minutes  = 6'd0;
          s.phase         = asn1t_pkg::PH_ZONE;
        end
      end else if (ph < asn1t_pkg::PH_AFTER) begin
        if (!is_digit) begin
          ok = 1'b0;
        end else if (!ph[0]) begin
          s.high_digit = dig;
          s.phase      = ph + 5'd1;
        end else if (pair < asn1t_pkg::FIELD_MIN[fld] || pair > asn1t_pkg::FIELD_MAX[fld]) begin
          ok = 1'b0;
        end else begin
          s.phase = ph + 5'd1;
          case (fld)
            asn1t_pkg::FLD_CENT: s.year = {7'd0, pair};
            asn1t_pkg::FLD_YY: begin
              if (format == asn1t_pkg::FMT_UTC) begin
                s.year = (pair < asn1t_pkg::YEAR_PIVOT) ? 14'd2000 + {7'd0, pair}
                                                        : 14'd1900 + {7'd0, pair};
              end else begin
                s.year = (st.year * 14'd100) + {7'd0, pair};
              end
            end
            asn1t_pkg::FLD_MON:  s.month  = pair[3:0];
            asn1t_pkg::FLD_DAY:  s.day    = pair[4:0];
            asn1t_pkg::FLD_HOUR: s.hour   = pair[4:0];
            asn1t_pkg::FLD_MIN:  s.minute = pair[5:0];
            default:             s.second = pair[5:0];
          endcase
        end
      end else if (ph == asn1t_pkg::PH_AFTER) begin
        if (ch == asn1t_pkg::CH_DOT && format == asn1t_pkg::FMT_GEN) begin
          s.phase = asn1t_pkg::PH_FRAC1;
        end else begin
          ok = 1'b0;
        end
      end else if (ph == asn1t_pkg::PH_FRAC1) begin
        if (is_digit) begin
          s.phase = asn1t_pkg::PH_FRAC;
        end else begin
          ok = 1'b0;
        end
      end else if (ph == asn1t_pkg::PH_FRAC) begin
        // drop fractional digits; a non-digit that is no zone start fails
        if (!is_digit) begin
          ok = 1'b0;
        end
      end else if (ph >= asn1t_pkg::PH_ZONE && ph <= asn1t_pkg::PH_ZONE_MLO) begin
        if (!is_digit) begin
          ok = 1'b0;
        end else if (ph[0]) begin
          // even offset from PH_ZONE: tens digit
          s.high_digit = dig;
          s.phase      = ph + 5'd1;
        end else if (ph == asn1t_pkg::PH_ZONE_MLO) begin
          if (pair > asn1t_pkg::ZONE_MIN_MAX) begin
            ok = 1'b0;
          end else begin
            s.zone_minutes = pair[5:0];
            s.phase        = asn1t_pkg::PH_DONE;
          end
        end else if (ph == asn1t_pkg::PH_ZONE + 5'd1) begin
          if (pair > asn1t_pkg::ZONE_HOUR_MAX) begin
            ok = 1'b0;
          end else begin
            s.zone_hours = pair[3:0];
            s.phase      = ph + 5'd1;
          end
        end else begin
          ok = 1'b0;
        end
      end else begin
        ok = 1'b0;
      end
      if (!ok) begin
        s.failed = 1'b1;
      end
    end
  end

  assign min_len = (format == asn1t_pkg::FMT_GEN) ? asn1t_pkg::MIN_LEN_GEN
                                                  : asn1t_pkg::MIN_LEN_UTC;
  assign good = !s.failed && (format <= asn1t_pkg::FMT_GEN) && (cnt >= min_len) &&
                ({1'b0, cnt} <= 7'(MAX_LEN)) &&
                (s.phase == asn1t_pkg::PH_AFTER || s.phase == asn1t_pkg::PH_FRAC ||
                 s.phase == asn1t_pkg::PH_DONE);

  always_comb begin
    res = '0;
    if (good) begin
      res.valid_res     = 1'b1;
      res.year          = s.year;
      res.month         = s.month;
      res.day           = s.day;
      res.hour          = s.hour;
      res.minute        = s.minute;
      res.second        = s.second;
      res.zone_present  = s.zone_present;
      res.zone_negative = s.zone_negative;
      res.zone_hours    = s.zone_hours;
      res.zone_minutes  = s.zone_minutes;
    end
  end

  // return to the start state once the string ends
  always_comb begin
    st_next = s;
    if (last) begin
      st_next = '0;
    end
  end

endmodule

`default_nettype wire

### rtl/core/asn1t_res_fifo.sv
// ----------------------------------------------------------------------------
// asn1t_res_fifo
// Two-entry result buffer: two slots addressed by read and write pointers.
// ----------------------------------------------------------------------------
`default_nettype none

module asn1t_res_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  asn1t_pkg::res_t push_data,
  input  logic            pop,
  output logic            room,
  output logic            head_valid,
  output asn1t_pkg::res_t head
);

  asn1t_pkg::res_t slot [0:1];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;
  logic            do_pop;

  assign do_pop     = pop && (count != 2'd0);
  assign room       = (count != 2'd2);
  assign head_valid = (count != 2'd0);
  assign head       = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/core/asn1_time_string_parser.sv
// ----------------------------------------------------------------------------
// asn1_time_string_parser
// Parses UTCTime / GeneralizedTime strings into calendar and zone fields.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one character per beat with its format code; last marks
//   the final character. out_ch carries one result beat per string, issued
//   for the beat that had last set. Invalid strings give valid_res = 0 with
//   all other fields zero.
//   Throughput: one character per cycle unless in_ch.ready drops, set by
//   the single parse step between the input register and the result buffer.
//   A result is formed from its last character in the input register and
//   written to the result buffer, from which it is offered and taken.
//   The result buffer holds two results, so characters keep flowing while a
//   result waits. in_ch.ready drops only when a last character is waiting
//   in the input register and both result slots are full.
//   Reset clears the parse state, the input register and the result buffer;
//   the first character after reset starts a new string.
// ----------------------------------------------------------------------------
`default_nettype none

module asn1_time_string_parser #(
  parameter int MAX_LEN = 32
) (
  input  logic         clk,
  input  logic         rst,
  asn1t_in_if.sink     in_ch,
  asn1t_out_if.source  out_ch
);

  logic            q_valid;
  logic [7:0]      q_ch;
  logic [1:0]      q_format;
  logic            q_last;
  logic            proceed;
  logic            step_en;
  logic            room;
  asn1t_pkg::st_t  st;
  asn1t_pkg::st_t  st_next;
  asn1t_pkg::res_t res;
  asn1t_pkg::res_t head;

  assign proceed     = !q_last || room;
  assign step_en     = q_valid && proceed;
  assign in_ch.ready = !q_valid || proceed;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      q_valid <= 1'b1;
    end else if (proceed) begin
      q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      q_ch     <= in_ch.ch;
      q_format <= in_ch.format;
      q_last   <= in_ch.last;
    end
  end

  asn1t_step #(
    .MAX_LEN (MAX_LEN)
  ) u_step (
    .st      (st),
    .ch      (q_ch),
    .format  (q_format),
    .last    (q_last),
    .st_next (st_next),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (step_en) begin
      st <= st_next;
    end
  end

  asn1t_res_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (step_en && q_last),
    .push_data  (res),
    .pop        (out_ch.ready),
    .room       (room),
    .head_valid (out_ch.valid),
    .head       (head)
  );

  assign out_ch.valid_res     = head.valid_res;
  assign out_ch.year          = head.year;
  assign out_ch.month         = head.month;
  assign out_ch.day           = head.day;
  assign out_ch.hour          = head.hour;
  assign out_ch.minute        = head.minute;
  assign out_ch.second        = head.second;
  assign out_ch.zone_present  = head.zone_present;
  assign out_ch.zone_negative = head.zone_negative;
  assign out_ch.zone_hours    = head.zone_hours;
  assign out_ch.zone_minutes  = head.zone_minutes;

`ifndef SYNTHESIS
  // stall only with a pending end of string and a full result buffer
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ch.ready |-> (q_valid && q_last && !room))
    else $error("input stalled without a blocked result");

  // parse state returns to start after the end of a string
  a_state_clear: assert property (@(posedge clk) disable iff (rst)
    (step_en && q_last) |=> (st.char_count == 6'd0 && !st.failed))
    else $error("parse state not cleared after last character");

  // an invalid result carries zero fields
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.valid_res) |-> (out_ch.year == 14'd0 &&
      out_ch.month == 4'd0 && !out_ch.zone_present))
    else $error("invalid result with nonzero fields");

  // character count advances by one on each non-last character until it saturates
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (step_en && !q_last && st.char_count != asn1t_pkg::CNT_MAX) |=>
      (st.char_count == $past(st.char_count) + 6'd1))
    else $error("character count did not advance");
`endif

endmodule

`default_nettype wire

### dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench for the ASN.1 time string parser. Strings go in one character
// per beat on the character channel. Each beat taken is run through a
// cycle-free model of the parse. The result beat for every string is checked
// field by field, in order, against the model or a typed-in value. A short
// table of hand-picked strings runs first, then random, mostly well-formed
// strings, with random gaps on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import asn1t_pkg::*;

  localparam int MAX_LEN    = 32;
  localparam int ITEMS      = 700;
  localparam int IDLE_LIMIT = 1000;
  localparam int DRAIN_WAIT = 10;
  localparam int NDIR       = 25;
  localparam res_t NO_TIME  = '0;

  logic clk = 1'b0;
  logic rst = 1'b1;

  asn1t_in_if  chr_bus ();
  asn1t_out_if time_bus ();

  asn1_time_string_parser #(.MAX_LEN(MAX_LEN)) dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (chr_bus),
    .out_ch (time_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // hand-picked strings; typed rows carry the result that must come back
  // --------------------------------------------------------------------------
  string dir_str [NDIR] = '{
    "4912312359Z",
    "500101000000+1259",
    "99991231235959.999-0000",
    "00000101000000",
    "202402291230-0530",
    "202401011230Z",
    "20240101123045.7",
    "9912312359",
    "991301000000Z",
    "9901000000Z",
    "9901012400Z",
    "990101000060Z",
    "9901010000+1300",
    "9901010000-0060",
    "9901010000Z",
    "9901010000Z",
    "990101000000.5Z",
    "9901010000ZZ",
    "20240101123045.Z",
    "20240101000000.1234567890123456Z",
    "20240101000000.12345678901234567Z",
    "9912312359Z",
    "20240229120000Z",
    "0000000000000000000000000000000000000000000000000000000000000000",
    "Z"
  };
  // format of the first character, then of all the others
  logic [1:0] dir_f0 [NDIR] = '{
    FMT_UTC, FMT_UTC, FMT_GEN, FMT_GEN, FMT_GEN, FMT_GEN, FMT_GEN, FMT_UTC,
    FMT_UTC, FMT_UTC, FMT_UTC, FMT_UTC, FMT_UTC, FMT_UTC, 2'd2, 2'd3,
    FMT_UTC, FMT_UTC, FMT_GEN, FMT_GEN, FMT_GEN, FMT_UTC, FMT_GEN, FMT_GEN, FMT_UTC
  };
  logic [1:0] dir_fmt [NDIR] = '{
    FMT_UTC, FMT_UTC, FMT_GEN, FMT_GEN, FMT_GEN, FMT_GEN, FMT_GEN, FMT_UTC,
    FMT_UTC, FMT_UTC, FMT_UTC, FMT_UTC, FMT_UTC, FMT_UTC, 2'd2, 2'd3,
    FMT_UTC, FMT_UTC, FMT_GEN, FMT_GEN, FMT_GEN, FMT_GEN, FMT_UTC, FMT_GEN, FMT_UTC
  };
  bit dir_typed [NDIR] = '{
    1, 1, 1, 1, 0, 0, 0, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 0, 1, 1, 0, 1, 1
  };
  res_t dir_res [NDIR] = '{
    {1'b1, 14'd2049, 4'd12, 5'd31, 5'd23, 6'd59, 6'd0, 1'b0, 1'b0, 4'd0, 6'd0},
    {1'b1, 14'd1950, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 1'b1, 1'b0, 4'd12, 6'd59},
    {1'b1, 14'd9999, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59, 1'b1, 1'b1, 4'd0, 6'd0},
    {1'b1, 14'd0, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 1'b0, 1'b0, 4'd0, 6'd0},
    NO_TIME, NO_TIME, NO_TIME, NO_TIME, NO_TIME, NO_TIME, NO_TIME, NO_TIME,
    NO_TIME, NO_TIME, NO_TIME, NO_TIME, NO_TIME, NO_TIME, NO_TIME, NO_TIME,
    NO_TIME, NO_TIME, NO_TIME, NO_TIME, NO_TIME
  };

  int pair_lo [0:6] = '{0, 0, 1, 1, 0, 0, 0};
  int pair_hi [0:6] = '{99, 99, 12, 31, 23, 59, 59};

  st_t        parse_st;        // model copy of the parse state
  res_t       pending_times[$];
  logic [7:0] msg_ch[$];
  logic [1:0] msg_fmt[$];
  bit         tx_eager;
  int         errors    = 0;
  int         n_chars   = 0;
  int         n_strings = 0;
  int         n_good    = 0;
  int         n_bad     = 0;
  int         idle_cycles = 0;

  task automatic flag(input string what, input int got, input int want);
    errors++;
    $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
  endtask

  // --------------------------------------------------------------------------
  // parse model
  // --------------------------------------------------------------------------
  function automatic bit zone_lead(input logic [7:0] c);
    if (c == CH_Z) begin
      parse_st.phase = PH_DONE;
      return 1'b1;
    end
    if (c == CH_PLUS || c == CH_MINUS) begin
      parse_st.zone_present  = 1'b1;
      parse_st.zone_negative = (c == CH_MINUS);
      parse_st.zone_hours    = '0;
      parse_st.zone_minutes  = '0;
      parse_st.phase         = PH_ZONE;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic predict_time_fields(input logic [7:0] c, input logic [1:0] f,
                                     input logic lst, output bit emits, output res_t r);
    bit ok;
    bit dig;
    bit fits;
    int n;
    int minlen;
    logic [2:0] fld;
    emits = 1'b0;
    r = NO_TIME;
    dig = (c >= CH_ZERO) && (c <= CH_NINE);
    n = int'(parse_st.high_digit) * 10 + int'(c[3:0]);
    if (parse_st.char_count == 0 && f == FMT_UTC) parse_st.phase = PH_YY_HI;
    if (parse_st.char_count < CNT_MAX) parse_st.char_count = parse_st.char_count + 1'b1;
    if (parse_st.char_count > MAX_LEN) parse_st.failed = 1'b1;
    if (!parse_st.failed) begin
      ok = 1'b1;
      if (parse_st.phase < PH_AFTER) begin
        if (parse_st.phase == PH_SEC_HI && (c == CH_Z || c == CH_PLUS || c == CH_MINUS)) begin
          ok = zone_lead(c);
          parse_st.second = '0;
        end else if (!dig) begin
          ok = 1'b0;
        end else if (!parse_st.phase[0]) begin
          parse_st.high_digit = c[3:0];
          parse_st.phase = parse_st.phase + 1'b1;
        end else begin
          fld = parse_st.phase[3:1];
          if (n < pair_lo[fld] || n > pair_hi[fld]) begin
            ok = 1'b0;
          end else begin
            case (fld)
              FLD_CENT: parse_st.year = 14'(n);
              FLD_YY: begin
                if (f == FMT_UTC) parse_st.year = (n < YEAR_PIVOT) ? 14'(2000 + n) : 14'(1900 + n);
                else parse_st.year = 14'(int'(parse_st.year) * 100 + n);
              end
              FLD_MON:  parse_st.month  = 4'(n);
              FLD_DAY:  parse_st.day    = 5'(n);
              FLD_HOUR: parse_st.hour   = 5'(n);
              FLD_MIN:  parse_st.minute = 6'(n);
              default:  parse_st.second = 6'(n);
            endcase
            parse_st.phase = parse_st.phase + 1'b1;
          end
        end
      end else if (parse_st.phase == PH_AFTER) begin
        if (c == CH_DOT && f == FMT_GEN) parse_st.phase = PH_FRAC1;
        else ok = zone_lead(c);
      end else if (parse_st.phase == PH_FRAC1) begin
        if (dig) parse_st.phase = PH_FRAC;
        else ok = 1'b0;
      end else if (parse_st.phase == PH_FRAC) begin
        // fraction digits are dropped
        if (!dig) ok = zone_lead(c);
      end else if (parse_st.phase >= PH_ZONE && parse_st.phase < PH_DONE) begin
        if (!dig) begin
          ok = 1'b0;
        end else if (parse_st.phase[0]) begin
          // odd phases here take the high digit of the pair
          parse_st.high_digit = c[3:0];
          parse_st.phase = parse_st.phase + 1'b1;
        end else if (parse_st.phase == PH_ZONE_MLO) begin
          if (n > ZONE_MIN_MAX) ok = 1'b0;
          else begin
            parse_st.zone_minutes = 6'(n);
            parse_st.phase = PH_DONE;
          end
        end else begin
          if (n > ZONE_HOUR_MAX) ok = 1'b0;
          else begin
            parse_st.zone_hours = 4'(n);
            parse_st.phase = parse_st.phase + 1'b1;
          end
        end
      end else begin
        ok = 1'b0;
      end
      if (!ok) parse_st.failed = 1'b1;
    end
    if (lst) begin
      emits = 1'b1;
      minlen = (f == FMT_GEN) ? MIN_LEN_GEN : MIN_LEN_UTC;
      fits = parse_st.char_count >= minlen && parse_st.char_count <= MAX_LEN;
      if (!parse_st.failed && (f == FMT_UTC || f == FMT_GEN) && fits &&
          (parse_st.phase == PH_AFTER || parse_st.phase == PH_FRAC ||
           parse_st.phase == PH_DONE))
        r = {1'b1, parse_st.year, parse_st.month, parse_st.day, parse_st.hour,
             parse_st.minute, parse_st.second, parse_st.zone_present,
             parse_st.zone_negative, parse_st.zone_hours, parse_st.zone_minutes};
      parse_st = '0;
    end
  endtask

  // --------------------------------------------------------------------------
  // random strings
  // --------------------------------------------------------------------------
  function automatic logic [7:0] odd_char();
    case ($urandom_range(0, 5))
      0: return CH_Z;
      1: return CH_PLUS;
      2: return CH_MINUS;
      3: return CH_DOT;
      4: return CH_ZERO + 8'($urandom_range(0, 9));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic put_digit_pair(input int lo, input int hi);
    int v;
    case ($urandom_range(0, 15))
      0: v = $urandom_range(0, 99);
      1, 2: v = lo;
      3, 4: v = hi;
      default: v = $urandom_range(lo, hi);
    endcase
    msg_ch.push_back(CH_ZERO + 8'(v / 10));
    msg_ch.push_back(CH_ZERO + 8'(v % 10));
  endtask

  task automatic build_random_text();
    int roll;
    int n;
    int pos;
    logic [1:0] f;
    msg_ch.delete();
    msg_fmt.delete();
    roll = $urandom_range(0, 99);
    f = (roll < 45) ? FMT_UTC : (roll < 90) ? FMT_GEN : 2'($urandom_range(2, 3));
    if ($urandom_range(0, 11) == 0) begin
      n = $urandom_range(1, 70);
      repeat (n) msg_ch.push_back(odd_char());
    end else begin
      if (f != FMT_UTC) put_digit_pair(0, 99);
      put_digit_pair(0, 99);
      put_digit_pair(1, 12);
      put_digit_pair(1, 31);
      put_digit_pair(0, 23);
      put_digit_pair(0, 59);
      if ($urandom_range(0, 9) < 7) begin
        put_digit_pair(0, 59);
        if ($urandom_range(0, 9) < ((f == FMT_GEN) ? 4 : 1)) begin
          msg_ch.push_back(CH_DOT);
          n = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 20) : $urandom_range(1, 4);
          repeat (n) msg_ch.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        end
      end
      case ($urandom_range(0, 2))
        0: ;
        1: msg_ch.push_back(CH_Z);
        default: begin
          msg_ch.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
          put_digit_pair(0, 12);
          put_digit_pair(0, 59);
        end
      endcase
      // break the sequence now and then
      if ($urandom_range(0, 4) == 0) begin
        pos = $urandom_range(0, msg_ch.size() - 1);
        case ($urandom_range(0, 3))
          0: msg_ch[pos] = odd_char();
          1: while (msg_ch.size() > pos + 1) void'(msg_ch.pop_back());
          2: msg_ch.push_back(odd_char());
          default: msg_ch.insert(pos, odd_char());
        endcase
      end
    end
    repeat (msg_ch.size()) msg_fmt.push_back(f);
    if ($urandom_range(0, 14) == 0)
      msg_fmt[$urandom_range(0, msg_fmt.size() - 1)] = 2'($urandom_range(0, 3));
  endtask

  // --------------------------------------------------------------------------
  // character channel
  // --------------------------------------------------------------------------
  task automatic send_char(input logic [7:0] c, input logic [1:0] f, input logic lst);
    int gap;
    gap = tx_eager ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      chr_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    chr_bus.valid  <= 1'b1;
    chr_bus.ch     <= c;
    chr_bus.format <= f;
    chr_bus.last   <= lst;
    @(posedge clk);
    while (!chr_bus.ready) @(posedge clk);
  endtask

  task automatic send_text(input bit typed, input res_t typed_res);
    int j;
    bit emits;
    bit lst;
    res_t r;
    tx_eager = ($urandom_range(0, 4) == 0);
    for (j = 0; j < msg_ch.size(); j++) begin
      lst = (j == msg_ch.size() - 1);
      send_char(msg_ch[j], msg_fmt[j], lst);
      n_chars++;
      predict_time_fields(msg_ch[j], msg_fmt[j], lst, emits, r);
      if (emits) pending_times.push_back(typed ? typed_res : r);
    end
    n_strings++;
  endtask

  // hold the character channel until every result is back
  task automatic drain_results();
    chr_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending_times.size() != 0) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // result channel
  // --------------------------------------------------------------------------
  task automatic check_time(input res_t got);
    res_t want;
    if (pending_times.size() == 0) begin
      flag("result with nothing pending, valid_res", got.valid_res, 0);
    end else begin
      want = pending_times.pop_front();
      if (got.valid_res !== want.valid_res) flag("valid_res", got.valid_res, want.valid_res);
      if (got.year !== want.year) flag("year", got.year, want.year);
      if (got.month !== want.month) flag("month", got.month, want.month);
      if (got.day !== want.day) flag("day", got.day, want.day);
      if (got.hour !== want.hour) flag("hour", got.hour, want.hour);
      if (got.minute !== want.minute) flag("minute", got.minute, want.minute);
      if (got.second !== want.second) flag("second", got.second, want.second);
      if (got.zone_present !== want.zone_present)
        flag("zone_present", got.zone_present, want.zone_present);
      if (got.zone_negative !== want.zone_negative)
        flag("zone_negative", got.zone_negative, want.zone_negative);
      if (got.zone_hours !== want.zone_hours)
        flag("zone_hours", got.zone_hours, want.zone_hours);
      if (got.zone_minutes !== want.zone_minutes)
        flag("zone_minutes", got.zone_minutes, want.zone_minutes);
    end
    if (got.valid_res === 1'b1) n_good++;
    else n_bad++;
  endtask

  initial begin : result_sink
    int gap;
    int calm;
    calm = 0;
    forever begin
      if (calm > 0) begin
        gap = 0;
        calm--;
      end else begin
        gap = $urandom_range(0, 4);
        if ($urandom_range(0, 7) == 0) calm = 8;
      end
      if (gap > 0) begin
        time_bus.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      time_bus.ready <= 1'b1;
      @(posedge clk);
      while (time_bus.valid !== 1'b1) @(posedge clk);
      check_time({time_bus.valid_res, time_bus.year, time_bus.month, time_bus.day,
                  time_bus.hour, time_bus.minute, time_bus.second, time_bus.zone_present,
                  time_bus.zone_negative, time_bus.zone_hours, time_bus.zone_minutes});
    end
  end

  // end the run when no beat moves for too long
  always @(posedge clk) begin
    if ((chr_bus.valid && chr_bus.ready) || (time_bus.valid && time_bus.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
      $display("tb failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int i;
    int j;
    string s;
    parse_st = '0;
    chr_bus.valid  <= 1'b0;
    chr_bus.ch     <= '0;
    chr_bus.format <= FMT_UTC;
    chr_bus.last   <= 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < NDIR; i++) begin
      s = dir_str[i];
      msg_ch.delete();
      msg_fmt.delete();
      for (j = 0; j < s.len(); j++) begin
        msg_ch.push_back(s[j]);
        msg_fmt.push_back((j == 0) ? dir_f0[i] : dir_fmt[i]);
      end
      send_text(dir_typed[i], dir_res[i]);
    end
    drain_results();

    while (n_chars < ITEMS) begin
      build_random_text();
      send_text(1'b0, NO_TIME);
      if ($urandom_range(0, 29) == 0) drain_results();
    end

    drain_results();
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("%0d strings in %0d characters; %0d valid times and %0d rejected strings seen",
             n_strings, n_chars, n_good, n_bad);
    $display("%0d mismatches", errors);
    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
